FILE: hw/rtl/prq_pkg.sv
`default_nettype none

package prq_pkg;

    localparam int PRIO_LEVELS = 32;
    localparam int FIFO_DEPTH  = 8;
    localparam int TASK_COUNT  = 64;

    localparam int PRIO_W  = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int SLOT_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int TASK_W  = $clog2(TASK_COUNT);
    localparam int ADDR_W  = PRIO_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [7:0] LOCK_MAX = 8'd255;

    localparam logic [2:0] OP_READY  = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOCK   = 3'd2;
    localparam logic [2:0] OP_UNLOCK = 3'd3;
    localparam logic [2:0] OP_SCHED  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [5:0] task_id;
        logic [4:0] task_prio;
    } req_t;

    typedef struct packed {
        logic       switch_now;
        logic [5:0] next_task;
        logic [4:0] top_prio;
        logic       any_ready;
        logic [7:0] lock_level;
        logic [1:0] status;
    } rsp_t;

    // Lowest set index of the priority bitmap.
    function automatic logic [PRIO_W-1:0] first_set(input logic [PRIO_LEVELS-1:0] map);
        logic [PRIO_W-1:0] pos;
        pos = '0;
        for (int k = PRIO_LEVELS - 1; k >= 0; k--)
        begin
            if (map[k])
            begin
                pos = PRIO_W'(k);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/prq_ram.sv
`default_nettype none

module prq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/prq_core.sv
`default_nettype none

module prq_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire prq_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output prq_pkg::rsp_t      res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_HEAD_RD,
        S_HEAD_CMP,
        S_OUT
    } state_t;

    state_t                               state_reg;
    logic [prq_pkg::TASK_W-1:0]           id_reg;
    logic [prq_pkg::PRIO_W-1:0]           pr_reg;
    logic [prq_pkg::CNT_W-1:0]            idx_reg;
    logic [prq_pkg::CNT_W-1:0]            n_reg;
    logic [1:0]                           status_reg;
    logic                                 sched_reg;
    logic [prq_pkg::PRIO_LEVELS-1:0]      bitmap_reg;
    logic [prq_pkg::CNT_W-1:0]            count_reg [prq_pkg::PRIO_LEVELS];
    logic [7:0]                           lock_reg;
    logic [prq_pkg::TASK_W-1:0]           run_task_reg;
    logic                                 run_valid_reg;
    prq_pkg::rsp_t                        res_reg;

    logic                                 we;
    logic [prq_pkg::ADDR_W-1:0]           waddr;
    logic [prq_pkg::TASK_W-1:0]           wdata;
    logic [prq_pkg::ADDR_W-1:0]           raddr;
    logic [prq_pkg::TASK_W-1:0]           rdata;

    logic [prq_pkg::PRIO_W-1:0]           in_pr;
    logic                                 in_ok;
    logic [prq_pkg::CNT_W-1:0]            in_cnt;
    logic [prq_pkg::CNT_W:0]              idx_p1;
    logic [prq_pkg::CNT_W:0]              idx_p2;
    logic [prq_pkg::PRIO_W-1:0]           top;
    logic                                 any;
    logic [prq_pkg::TASK_W-1:0]           head;
    logic                                 sw;

    assign in_pr  = prq_pkg::PRIO_W'(req.task_prio);
    assign in_ok  = (int'(req.task_prio) < prq_pkg::PRIO_LEVELS)
                 && (int'(req.task_id) < prq_pkg::TASK_COUNT);
    assign in_cnt = count_reg[in_pr];
    assign idx_p1 = {1'b0, idx_reg} + (prq_pkg::CNT_W+1)'(1);
    assign idx_p2 = {1'b0, idx_reg} + (prq_pkg::CNT_W+1)'(2);
    assign top    = prq_pkg::first_set(bitmap_reg);
    assign any    = |bitmap_reg;
    assign head   = any ? rdata : '0;
    assign sw     = sched_reg && (lock_reg == 8'd0) && any
                 && !(run_valid_reg && (run_task_reg == head));

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    // Memory port control: one write and one registered read per cycle.
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req.operation == prq_pkg::OP_READY && in_ok
                    && int'(in_cnt) < prq_pkg::FIFO_DEPTH)
                begin
                    we    = 1'b1;
                    waddr = {in_pr, in_cnt[prq_pkg::SLOT_W-1:0]};
                    wdata = prq_pkg::TASK_W'(req.task_id);
                end
            end
            S_SRCH_RD:  raddr = {pr_reg, idx_reg[prq_pkg::SLOT_W-1:0]};
            S_SHIFT_RD: raddr = {pr_reg, idx_p1[prq_pkg::SLOT_W-1:0]};
            S_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = {pr_reg, idx_reg[prq_pkg::SLOT_W-1:0]};
                wdata = rdata;
            end
            S_HEAD_RD:  raddr = {top, {prq_pkg::SLOT_W{1'b0}}};
            S_SRCH_CMP, S_HEAD_CMP, S_OUT: ;
            default: ;
        endcase
    end

    prq_ram #(
        .WIDTH(prq_pkg::TASK_W),
        .DEPTH(prq_pkg::MEM_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pr_reg        <= '0;
            bitmap_reg    <= '0;
            lock_reg      <= '0;
            run_task_reg  <= '0;
            run_valid_reg <= 1'b0;
            sched_reg     <= 1'b0;
            for (int p = 0; p < prq_pkg::PRIO_LEVELS; p++)
            begin
                count_reg[p] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        id_reg     <= prq_pkg::TASK_W'(req.task_id);
                        pr_reg     <= in_pr;
                        idx_reg    <= '0;
                        n_reg      <= in_cnt;
                        case (req.operation)
                            prq_pkg::OP_READY:
                            begin
                                sched_reg <= 1'b0;
                                state_reg <= S_HEAD_RD;
                                if (in_ok && int'(in_cnt) < prq_pkg::FIFO_DEPTH)
                                begin
                                    status_reg        <= prq_pkg::ST_OK;
                                    count_reg[in_pr]  <= in_cnt + prq_pkg::CNT_W'(1);
                                    bitmap_reg[in_pr] <= 1'b1;
                                end
                                else
                                begin
                                    status_reg <= prq_pkg::ST_FULL;
                                end
                            end
                            prq_pkg::OP_REMOVE:
                            begin
                                sched_reg  <= 1'b0;
                                status_reg <= prq_pkg::ST_MISSING;
                                if (in_ok && in_cnt != '0)
                                begin
                                    state_reg <= S_SRCH_RD;
                                end
                                else
                                begin
                                    state_reg <= S_HEAD_RD;
                                end
                            end
                            prq_pkg::OP_LOCK:
                            begin
                                sched_reg  <= 1'b0;
                                status_reg <= prq_pkg::ST_OK;
                                state_reg  <= S_HEAD_RD;
                                if (lock_reg != prq_pkg::LOCK_MAX)
                                begin
                                    lock_reg <= lock_reg + 8'd1;
                                end
                            end
                            prq_pkg::OP_UNLOCK:
                            begin
                                status_reg <= prq_pkg::ST_OK;
                                state_reg  <= S_HEAD_RD;
                                if (lock_reg != 8'd0)
                                begin
                                    lock_reg  <= lock_reg - 8'd1;
                                    sched_reg <= (lock_reg == 8'd1);
                                end
                                else
                                begin
                                    sched_reg <= 1'b0;
                                end
                            end
                            prq_pkg::OP_SCHED:
                            begin
                                sched_reg  <= 1'b1;
                                status_reg <= prq_pkg::ST_OK;
                                state_reg  <= S_HEAD_RD;
                            end
                            default:
                            begin
                                sched_reg  <= 1'b0;
                                status_reg <= prq_pkg::ST_OK;
                                state_reg  <= S_HEAD_RD;
                            end
                        endcase
                    end
                end
                S_SRCH_RD: state_reg <= S_SRCH_CMP;
                S_SRCH_CMP:
                begin
                    if (rdata == id_reg)
                    begin
                        status_reg <= prq_pkg::ST_OK;
                        if (idx_p1 < {1'b0, n_reg})
                        begin
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            count_reg[pr_reg]  <= n_reg - prq_pkg::CNT_W'(1);
                            bitmap_reg[pr_reg] <= (n_reg != prq_pkg::CNT_W'(1));
                            state_reg          <= S_HEAD_RD;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_p1[prq_pkg::CNT_W-1:0];
                        if (idx_p1 == {1'b0, n_reg})
                        begin
                            state_reg <= S_HEAD_RD;
                        end
                        else
                        begin
                            state_reg <= S_SRCH_RD;
                        end
                    end
                end
                S_SHIFT_RD: state_reg <= S_SHIFT_WR;
                S_SHIFT_WR:
                begin
                    idx_reg <= idx_p1[prq_pkg::CNT_W-1:0];
                    if (idx_p2 < {1'b0, n_reg})
                    begin
                        state_reg <= S_SHIFT_RD;
                    end
                    else
                    begin
                        // A gap was closed, so at least one entry remains.
                        count_reg[pr_reg] <= n_reg - prq_pkg::CNT_W'(1);
                        state_reg         <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD: state_reg <= S_HEAD_CMP;
                S_HEAD_CMP:
                begin
                    if (sw)
                    begin
                        run_task_reg  <= head;
                        run_valid_reg <= 1'b1;
                    end
                    res_reg.switch_now <= sw;
                    res_reg.next_task  <= 6'(head);
                    res_reg.top_prio   <= any ? 5'(top) : 5'd0;
                    res_reg.any_ready  <= any;
                    res_reg.lock_level <= lock_reg;
                    res_reg.status     <= status_reg;
                    state_reg          <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_bitmap_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (bitmap_reg[0] == (count_reg[0] != '0)))
        else $error("bitmap bit disagrees with FIFO count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg[pr_reg]) <= prq_pkg::FIFO_DEPTH)
        else $error("FIFO count above depth");

    a_switch_sets_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD_CMP && sw) |=> (run_valid_reg && run_task_reg == res_reg.next_task))
        else $error("switch did not update running task");

    a_lock_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(lock_reg))
        else $error("lock count changed outside accept");

endmodule

`default_nettype wire

FILE: hw/rtl/priority_ready_queue_scheduler_top.sv
// Ready-queue scheduler: one FIFO of task ids per priority in a single RAM, a bitmap of
// non-empty priorities and a lock count. Each item yields exactly one result item. Make
// ready, lock, unlock, schedule and unused codes pass through accept, head read, decision
// and output register. Remove adds a search of the entries up to and including the match,
// each a read and a compare, plus a read and a write for each entry shifted behind it;
// the single RAM port serializes these steps. A new item is accepted once the result has
// moved to the output register.
`default_nettype none

module priority_ready_queue_scheduler_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire prq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output prq_pkg::rsp_t      rsp
);

    logic          res_valid;
    logic          res_ready;
    prq_pkg::rsp_t res;
    logic          rsp_valid_reg;
    prq_pkg::rsp_t rsp_reg;

    assign res_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    prq_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
